// ----- src/gne_pkg.sv -----
package gne_pkg;

  // Grid limits; cell coordinates are 8 bits, so the map is 256 x 256
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ROW_AW     = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 9;
  localparam int COST_W     = 40;
  localparam int STEP_W     = 16;
  localparam int NB_COUNT   = 8;

  // Input opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_LIFE_COST_MODE = 3'd2;
  localparam logic [2:0] REG_EIGHT_WAY_MODE = 3'd3;
  localparam logic [2:0] REG_STRAIGHT_COST  = 3'd4;
  localparam logic [2:0] REG_DIAGONAL_COST  = 3'd5;

  // Neighbor order: left, right, up, down, up-left, up-right, down-right, down-left
  localparam int NB_LEFT  = 0;
  localparam int NB_RIGHT = 1;
  localparam int NB_UP    = 2;
  localparam int NB_DOWN  = 3;
  localparam int NB_UL    = 4;
  localparam int NB_UR    = 5;
  localparam int NB_DR    = 6;
  localparam int NB_DL    = 7;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic [COST_W-1:0] parent_cost;
    logic              blocked;
  } item_t;

  typedef struct packed {
    logic              child_valid;
    logic [7:0]        child_x;
    logic [7:0]        child_y;
    logic [COST_W-1:0] child_cost;
    logic              last;
  } result_t;

  // Effective configuration seen by the sequencer
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              life_cost_mode;
    logic              eight_way_mode;
    logic [STEP_W-1:0] straight_cost;
    logic [STEP_W-1:0] diagonal_cost;
  } cfg_t;

  // Row-wide obstacle memory access
  typedef struct packed {
    logic                 rd_en;
    logic [ROW_AW-1:0]    rd_row;
    logic                 wr_en;
    logic [ROW_AW-1:0]    wr_row;
    logic [MAX_WIDTH-1:0] wr_data;
  } ram_req_t;

  // Grid size of 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    begin
      if (v == '0) begin
        r = SIZE_W'(1);
      end else if (v > maxv) begin
        r = maxv;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

// ----- src/gne_obst_ram.sv -----
module gne_obst_ram (
  input  logic                              clk,
  input  gne_pkg::ram_req_t                 req,
  output logic [gne_pkg::MAX_WIDTH-1:0]     rd_data
);

  // One row of obstacle bits per entry
  logic [gne_pkg::MAX_WIDTH-1:0] mem [gne_pkg::MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_row];
    end
  end

endmodule

// ----- src/gne_seq.sv -----
module gne_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  gne_pkg::cfg_t                     cfg,
  input  logic                              start,
  input  gne_pkg::item_t                    item,
  output logic                              busy,
  output logic                              result_valid,
  output gne_pkg::result_t                  result,
  output gne_pkg::ram_req_t                 ram_req,
  input  logic [gne_pkg::MAX_WIDTH-1:0]     ram_rd_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_WB,
    S_EX_R1,
    S_EX_R2,
    S_EX_R3,
    S_EX_EMIT
  } state_t;

  localparam int SUM_W = gne_pkg::COST_W + 1;
  localparam int PROD_W = gne_pkg::STEP_W + 8;

  state_t state;
  logic [gne_pkg::ROW_AW-1:0]    clr_row;
  logic [7:0]                    cx;
  logic [7:0]                    cy;
  logic [gne_pkg::COST_W-1:0]    g;
  logic                          wr_bit;
  logic [gne_pkg::MAX_WIDTH-1:0] row_mid;
  logic [gne_pkg::MAX_WIDTH-1:0] row_up;
  logic [PROD_W-1:0]             step_s;
  logic [PROD_W-1:0]             step_d;
  logic [gne_pkg::COST_W-1:0]    sum_s;
  logic [gne_pkg::COST_W-1:0]    sum_d;
  logic [gne_pkg::NB_COUNT-1:0]  mask;

  logic [gne_pkg::NB_COUNT-1:0]  mask_new;
  logic [gne_pkg::NB_COUNT-1:0]  mask_next;
  logic [gne_pkg::NB_COUNT-1:0]  pick;
  logic [2:0]                    pick_idx;
  logic [7:0]                    xm1;
  logic [7:0]                    xp1;
  logic [7:0]                    ym1;
  logic [7:0]                    yp1;
  logic                          ok_l;
  logic                          ok_r;
  logic                          ok_u;
  logic                          ok_d;
  logic                          parent_in;
  logic [SUM_W-1:0]              add_s;
  logic [SUM_W-1:0]              add_d;
  logic [7:0]                    mult_y;
  logic [7:0]                    nx;
  logic [7:0]                    ny;
  logic [gne_pkg::MAX_WIDTH-1:0] wb_row;

  assign busy = (state != S_IDLE);

  // Neighbor coordinates and bounds
  assign xm1 = cx - 8'd1;
  assign xp1 = cx + 8'd1;
  assign ym1 = cy - 8'd1;
  assign yp1 = cy + 8'd1;
  assign parent_in = ({1'b0, cx} < cfg.width) && ({1'b0, cy} < cfg.height);
  assign ok_l = (cx != 8'd0);
  assign ok_r = (({1'b0, cx} + 9'd1) < cfg.width);
  assign ok_u = (cy != 8'd0);
  assign ok_d = (({1'b0, cy} + 9'd1) < cfg.height);

  // Open-neighbor mask; the lower row arrives straight from the memory
  always_comb begin
    mask_new = '0;
    mask_new[gne_pkg::NB_LEFT]  = ok_l && !row_mid[xm1];
    mask_new[gne_pkg::NB_RIGHT] = ok_r && !row_mid[xp1];
    mask_new[gne_pkg::NB_UP]    = ok_u && !row_up[cx];
    mask_new[gne_pkg::NB_DOWN]  = ok_d && !ram_rd_data[cx];
    if (cfg.eight_way_mode) begin
      mask_new[gne_pkg::NB_UL] = ok_u && ok_l && !row_up[xm1];
      mask_new[gne_pkg::NB_UR] = ok_u && ok_r && !row_up[xp1];
      mask_new[gne_pkg::NB_DR] = ok_d && ok_r && !ram_rd_data[xp1];
      mask_new[gne_pkg::NB_DL] = ok_d && ok_l && !ram_rd_data[xm1];
    end
    if (!parent_in) begin
      mask_new = '0;
    end
  end

  // Lowest open neighbor first
  always_comb begin
    pick_idx = 3'd0;
    for (int i = gne_pkg::NB_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick_idx = 3'(i);
      end
    end
    pick = gne_pkg::NB_COUNT'(1) << pick_idx;
    mask_next = mask & ~pick;
  end

  always_comb begin
    case (pick_idx)
      3'(gne_pkg::NB_LEFT):  begin nx = xm1; ny = cy;  end
      3'(gne_pkg::NB_RIGHT): begin nx = xp1; ny = cy;  end
      3'(gne_pkg::NB_UP):    begin nx = cx;  ny = ym1; end
      3'(gne_pkg::NB_DOWN):  begin nx = cx;  ny = yp1; end
      3'(gne_pkg::NB_UL):    begin nx = xm1; ny = ym1; end
      3'(gne_pkg::NB_UR):    begin nx = xp1; ny = ym1; end
      3'(gne_pkg::NB_DR):    begin nx = xp1; ny = yp1; end
      default:               begin nx = xm1; ny = yp1; end
    endcase
  end

  // Step cost and saturating child cost
  assign mult_y = cfg.life_cost_mode ? cy : 8'd1;
  assign add_s = {1'b0, g} + SUM_W'(step_s);
  assign add_d = {1'b0, g} + SUM_W'(step_d);

  // Write-back row with one bit replaced
  always_comb begin
    wb_row = ram_rd_data;
    wb_row[cx] = wr_bit;
  end

  // Memory requests
  always_comb begin
    ram_req = '0;
    case (state)
      S_CLEAR: begin
        ram_req.wr_en = 1'b1;
        ram_req.wr_row = clr_row;
      end
      S_IDLE: begin
        ram_req.rd_en = start;
        ram_req.rd_row = item.cell_y;
      end
      S_WR_WB: begin
        ram_req.wr_en = 1'b1;
        ram_req.wr_row = cy;
        ram_req.wr_data = wb_row;
      end
      S_EX_R1: begin
        ram_req.rd_en = 1'b1;
        ram_req.rd_row = ym1;
      end
      S_EX_R2: begin
        ram_req.rd_en = 1'b1;
        ram_req.rd_row = yp1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_row <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == gne_pkg::ROW_AW'(gne_pkg::MAX_HEIGHT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cx <= item.cell_x;
            cy <= item.cell_y;
            g <= item.parent_cost;
            wr_bit <= item.blocked;
            state <= (item.opcode == gne_pkg::OP_WRITE) ? S_WR_WB : S_EX_R1;
          end
        end
        S_WR_WB: begin
          state <= S_IDLE;
        end
        S_EX_R1: begin
          row_mid <= ram_rd_data;
          step_s <= PROD_W'(cfg.straight_cost) * PROD_W'(mult_y);
          step_d <= PROD_W'(cfg.diagonal_cost) * PROD_W'(mult_y);
          state <= S_EX_R2;
        end
        S_EX_R2: begin
          row_up <= ram_rd_data;
          sum_s <= add_s[gne_pkg::COST_W] ? '1 : add_s[gne_pkg::COST_W-1:0];
          sum_d <= add_d[gne_pkg::COST_W] ? '1 : add_d[gne_pkg::COST_W-1:0];
          state <= S_EX_R3;
        end
        S_EX_R3: begin
          mask <= mask_new;
          state <= S_EX_EMIT;
        end
        S_EX_EMIT: begin
          result_valid <= 1'b1;
          if (mask == '0) begin
            // no open neighbor: one invalid transaction
            result.child_valid <= 1'b0;
            result.child_x <= '0;
            result.child_y <= '0;
            result.child_cost <= '0;
            result.last <= 1'b1;
            state <= S_IDLE;
          end else begin
            result.child_valid <= 1'b1;
            result.child_x <= nx;
            result.child_y <= ny;
            result.child_cost <= pick_idx[2] ? sum_d : sum_s;
            result.last <= (mask_next == '0);
            mask <= mask_next;
            if (mask_next == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/grid_neighbor_expand_core.sv -----
// Neighbor generator for grid path search over a 256 x 256 one-bit obstacle
// map. After reset the map is swept clear one row per cycle with busy high;
// configuration writes are taken throughout. An item is taken when start is
// high and busy is low. A write item reads the row, then writes back the
// modified row, and gives no result. An expand item makes three row reads
// through the single read port of the obstacle memory, then gives 1 to 8
// results, one per cycle. Results appear for one cycle each with
// result_valid high and must be taken then; the receiver cannot hold them
// off. The last result of an expand has last set. Configure only while busy
// is low and no results are pending.
module grid_neighbor_expand_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  gne_pkg::item_t           item,
  output logic                     busy,
  output logic                     result_valid,
  output gne_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  logic [gne_pkg::SIZE_W-1:0] grid_width;
  logic [gne_pkg::SIZE_W-1:0] grid_height;
  logic                       life_cost_mode;
  logic                       eight_way_mode;
  logic [gne_pkg::STEP_W-1:0] straight_cost;
  logic [gne_pkg::STEP_W-1:0] diagonal_cost;

  gne_pkg::cfg_t              cfg;
  gne_pkg::ram_req_t          ram_req;
  logic [gne_pkg::MAX_WIDTH-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= gne_pkg::SIZE_W'(256);
      grid_height <= gne_pkg::SIZE_W'(256);
      life_cost_mode <= 1'b0;
      eight_way_mode <= 1'b0;
      straight_cost <= 16'd1000;
      diagonal_cost <= 16'd1414;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gne_pkg::REG_GRID_WIDTH:     grid_width <= cfg_data[gne_pkg::SIZE_W-1:0];
        gne_pkg::REG_GRID_HEIGHT:    grid_height <= cfg_data[gne_pkg::SIZE_W-1:0];
        gne_pkg::REG_LIFE_COST_MODE: life_cost_mode <= cfg_data[0];
        gne_pkg::REG_EIGHT_WAY_MODE: eight_way_mode <= cfg_data[0];
        gne_pkg::REG_STRAIGHT_COST:  straight_cost <= cfg_data;
        gne_pkg::REG_DIAGONAL_COST:  diagonal_cost <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective grid size; the other fields pass straight through
  always_comb begin
    cfg.width = gne_pkg::clamp_size(grid_width,
                                    gne_pkg::SIZE_W'(gne_pkg::MAX_WIDTH));
    cfg.height = gne_pkg::clamp_size(grid_height,
                                     gne_pkg::SIZE_W'(gne_pkg::MAX_HEIGHT));
    cfg.life_cost_mode = life_cost_mode;
    cfg.eight_way_mode = eight_way_mode;
    cfg.straight_cost = straight_cost;
    cfg.diagonal_cost = diagonal_cost;
  end

  gne_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  gne_obst_ram u_ram (
    .clk    (clk),
    .req    (ram_req),
    .rd_data(ram_rd_data)
  );

endmodule

// ----- verif/grid_neighbor_expand_core_tb.sv -----
`timescale 1ns / 100ps

module grid_neighbor_expand_core_tb;

  localparam logic [gne_pkg::COST_W-1:0] COST_SAT = '1;
  // Register indexes with no register behind them
  localparam logic [2:0]        REG_SPARE_A = 3'd6;
  localparam logic [2:0]        REG_SPARE_B = 3'd7;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             start        = 1'b0;
  gne_pkg::item_t   item         = '0;
  logic             busy;
  logic             result_valid;
  gne_pkg::result_t result;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index    = '0;
  logic [15:0]      cfg_data     = '0;

  grid_neighbor_expand_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the obstacle map and the register file
  bit                         obstacle_bits [0:gne_pkg::MAX_WIDTH*gne_pkg::MAX_HEIGHT-1];
  logic [gne_pkg::SIZE_W-1:0] grid_w        = 9'd256;
  logic [gne_pkg::SIZE_W-1:0] grid_h        = 9'd256;
  logic                       life_mode     = 1'b0;
  logic                       diag_mode     = 1'b0;
  logic [gne_pkg::STEP_W-1:0] straight_step = 16'd1000;
  logic [gne_pkg::STEP_W-1:0] diag_step     = 16'd1414;

  // Neighbor offsets in generation order
  int nb_dx [0:7] = '{-1, 1, 0, 0, -1, 1, 1, -1};
  int nb_dy [0:7] = '{0, 0, -1, 1, -1, -1, 1, 1};

  gne_pkg::result_t pending_children [$];
  gne_pkg::result_t want;
  int      mismatch_count;
  int      items_sent;
  int      expands_sent;
  int      children_checked;
  int      empty_checked;
  int      cfg_writes;
  bit      idle_en = 1'b1;

  function automatic int eff_size(input logic [gne_pkg::SIZE_W-1:0] v, input int cap);
    if (v == '0) return 1;
    return (v > cap) ? cap : int'(v);
  endfunction

  function automatic gne_pkg::item_t make_item(input logic op, input logic [7:0] x,
                                               input logic [7:0] y,
                                               input logic [gne_pkg::COST_W-1:0] g,
                                               input logic blk);
    gne_pkg::item_t it;
    it.opcode      = op;
    it.cell_x      = x;
    it.cell_y      = y;
    it.parent_cost = g;
    it.blocked     = blk;
    return it;
  endfunction

  // Append one expected result at the tail
  task automatic queue_child(input gne_pkg::result_t r);
    pending_children = {pending_children, r};
  endtask

  // Map update or list of children for one accepted transaction
  task automatic expand_children(input gne_pkg::item_t it);
    int               w;
    int               h;
    int               nx;
    int               ny;
    int               n_moves;
    int               last_i;
    logic [7:0]       open_mask;
    logic [39:0]      step;
    logic [40:0]      sum;
    gne_pkg::result_t r;
    if (it.opcode == gne_pkg::OP_WRITE) begin
      obstacle_bits[{it.cell_y, it.cell_x}] = it.blocked;
      return;
    end
    expands_sent++;
    w = eff_size(grid_w, gne_pkg::MAX_WIDTH);
    h = eff_size(grid_h, gne_pkg::MAX_HEIGHT);
    n_moves = diag_mode ? gne_pkg::NB_COUNT : 4;
    open_mask = '0;
    last_i = -1;
    if (it.cell_x < w && it.cell_y < h) begin
      for (int i = 0; i < n_moves; i++) begin
        nx = int'(it.cell_x) + nb_dx[i];
        ny = int'(it.cell_y) + nb_dy[i];
        if (nx >= 0 && ny >= 0 && nx < w && ny < h &&
            !obstacle_bits[ny*gne_pkg::MAX_WIDTH + nx]) begin
          open_mask[i] = 1'b1;
          last_i = i;
        end
      end
    end
    if (last_i < 0) begin
      r = '0;
      r.last = 1'b1;
      queue_child(r);
      return;
    end
    for (int i = 0; i < n_moves; i++) begin
      if (open_mask[i]) begin
        step = (i >= gne_pkg::NB_UL) ? diag_step : straight_step;
        if (life_mode) step = step * it.cell_y;
        sum = {1'b0, it.parent_cost} + step;
        r.child_valid = 1'b1;
        r.child_x     = 8'(int'(it.cell_x) + nb_dx[i]);
        r.child_y     = 8'(int'(it.cell_y) + nb_dy[i]);
        r.child_cost  = sum[gne_pkg::COST_W] ? COST_SAT : sum[gne_pkg::COST_W-1:0];
        r.last        = (i == last_i);
        queue_child(r);
      end
    end
  endtask

  // One input transaction; each random idle cycle is one the core could accept in
  task automatic send_item(input gne_pkg::item_t it);
    if (idle_en) begin
      while ($urandom_range(0, 99) < 31) begin
        start <= 1'b0;
        @(posedge clk);
        while (busy) @(posedge clk);
      end
    end
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expand_children(it);
    items_sent++;
  endtask

  // Hold the sender until all children are out and the core is idle
  task automatic settle();
    start <= 1'b0;
    while (pending_children.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Leaves valid high; the caller lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (idx)
      gne_pkg::REG_GRID_WIDTH:     grid_w        = val[gne_pkg::SIZE_W-1:0];
      gne_pkg::REG_GRID_HEIGHT:    grid_h        = val[gne_pkg::SIZE_W-1:0];
      gne_pkg::REG_LIFE_COST_MODE: life_mode     = val[0];
      gne_pkg::REG_EIGHT_WAY_MODE: diag_mode     = val[0];
      gne_pkg::REG_STRAIGHT_COST:  straight_step = val;
      gne_pkg::REG_DIAGONAL_COST:  diag_step     = val;
      default: ;
    endcase
  endtask

  // Full register set; spare indexes get junk that must be dropped
  task automatic set_grid(input logic [15:0] w, input logic [15:0] h,
                          input logic life, input logic diag,
                          input logic [15:0] sc, input logic [15:0] dc);
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    write_reg(gne_pkg::REG_GRID_WIDTH, w);
    write_reg(gne_pkg::REG_GRID_HEIGHT, h);
    write_reg(gne_pkg::REG_LIFE_COST_MODE, {15'($urandom), life});
    write_reg(gne_pkg::REG_EIGHT_WAY_MODE, {15'($urandom), diag});
    write_reg(gne_pkg::REG_STRAIGHT_COST, sc);
    write_reg(gne_pkg::REG_DIAGONAL_COST, dc);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [gne_pkg::COST_W-1:0] rand_cost();
    logic [63:0] v;
    int          r;
    v = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return COST_SAT - gne_pkg::COST_W'($urandom_range(0, 300000));
    return v[gne_pkg::COST_W-1:0];
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd256;
      3:       return 16'd511;
      4:       return 16'($urandom_range(257, 511)) | 16'hFE00;
      5:       return 16'($urandom_range(17, 255));
      default: return 16'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_base(input int lim);
    if (lim <= 16) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return lim - 8;
      default: return $urandom_range(0, lim - 8);
    endcase
  endfunction

  // Mostly a small window at an edge of the grid, now and then anywhere
  function automatic logic [7:0] pick_coord(input int base, input int lim);
    int v;
    if ($urandom_range(0, 99) < 6) return 8'($urandom_range(0, 255));
    if (lim <= 16) return 8'($urandom_range(0, lim));
    v = base + $urandom_range(0, 8);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Result checker: each child against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_children.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result valid=%b x=%0d y=%0d cost=%h last=%b",
                   $time, result.child_valid, result.child_x, result.child_y,
                   result.child_cost, result.last);
      end else begin
        want = pending_children.pop_front();
        if (want.child_valid) children_checked++;
        else empty_checked++;
        if (result.child_valid !== want.child_valid ||
            result.child_x     !== want.child_x ||
            result.child_y     !== want.child_y ||
            result.child_cost  !== want.child_cost ||
            result.last        !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch exp valid=%b x=%0d y=%0d cost=%h last=%b",
                     $time, want.child_valid, want.child_x, want.child_y,
                     want.child_cost, want.last);
            $display("%0t:          got valid=%b x=%0d y=%0d cost=%h last=%b",
                     $time, result.child_valid, result.child_x, result.child_y,
                     result.child_cost, result.last);
          end
        end
      end
    end
  end

  // Reset defaults: corners, a middle cell, one blocked neighbor
  task automatic test_default_grid();
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd0, 8'd0, '0, 1'b0));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd255, 8'd255, COST_SAT, 1'b1));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd128, 8'd64, rand_cost(), 1'b0));
    send_item(make_item(gne_pkg::OP_WRITE, 8'd1, 8'd0, rand_cost(), 1'b1));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd0, 8'd0, 40'd77, 1'b0));
    send_item(make_item(gne_pkg::OP_WRITE, 8'd1, 8'd0, '0, 1'b0));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd1, 8'd1, 40'd5, 1'b0));
  endtask

  // Diagonals, row-scaled cost, free moves out of row 0, saturation
  task automatic test_life_cost();
    settle();
    set_grid(16'd256, 16'd256, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd10, 8'd0, 40'd5, 1'b0));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd255, 8'd255, COST_SAT - 40'd100, 1'b0));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd100, 8'd200, '0, 1'b0));
  endtask

  // Every neighbor blocked gives the single empty result
  task automatic test_boxed_in();
    settle();
    set_grid(16'd256, 16'd256, 1'b0, 1'b1, 16'd1000, 16'd1414);
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx != 0 || dy != 0)
          send_item(make_item(gne_pkg::OP_WRITE, 8'(5 + dx), 8'(5 + dy), '0, 1'b1));
      end
    end
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd5, 8'd5, 40'd9, 1'b0));
  endtask

  // Grid sizes: parent outside, zero size, oversize clamped
  task automatic test_grid_limits();
    settle();
    set_grid(16'd10, 16'd10, 1'b0, 1'b0, 16'd3, 16'd4);
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd10, 8'd3, 40'd1, 1'b0));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd3, 8'd255, 40'd1, 1'b0));
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd9, 8'd9, 40'd1, 1'b0));
    settle();
    set_grid(16'd0, 16'd0, 1'b0, 1'b1, 16'd3, 16'd4);
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd0, 8'd0, 40'd2, 1'b0));
    settle();
    set_grid(16'hFFFF, 16'd300, 1'b1, 1'b0, 16'd7, 16'd9);
    send_item(make_item(gne_pkg::OP_EXPAND, 8'd255, 8'd0, 40'd2, 1'b0));
  endtask

  // Random phases, each under its own register setting
  task automatic test_random_traffic();
    int         base_x;
    int         base_y;
    int         lim_x;
    int         lim_y;
    logic [7:0] x;
    logic [7:0] y;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      if (phase == 5)
        set_grid(16'd256, 16'd256, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      else
        set_grid(pick_size(), pick_size(), 1'($urandom), 1'($urandom_range(0, 2) != 0),
                 pick_step(), pick_step());
      lim_x  = eff_size(grid_w, gne_pkg::MAX_WIDTH);
      lim_y  = eff_size(grid_h, gne_pkg::MAX_HEIGHT);
      base_x = pick_base(lim_x);
      base_y = pick_base(lim_y);
      // One phase runs back to back with no gaps
      idle_en = (phase != 2);
      for (int k = 0; k < 72; k++) begin
        x = pick_coord(base_x, lim_x);
        y = pick_coord(base_y, lim_y);
        if ($urandom_range(0, 99) < 35)
          send_item(make_item(gne_pkg::OP_WRITE, x, y, rand_cost(),
                              $urandom_range(0, 99) < 45));
        else
          send_item(make_item(gne_pkg::OP_EXPAND, x, y, rand_cost(), 1'($urandom)));
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_grid();
    test_life_cost();
    test_boxed_in();
    test_grid_limits();
    test_random_traffic();
    settle();
    repeat (16) @(posedge clk);
    $display("Sent %0d transactions (%0d expands) over %0d register writes",
             items_sent, expands_sent, cfg_writes);
    $display("Checked %0d children and %0d empty results, %0d mismatches",
             children_checked, empty_checked, mismatch_count);
    if (mismatch_count == 0 && pending_children.size() == 0) begin
      $display("grid_neighbor_expand_core verification clean");
    end else begin
      $display("grid_neighbor_expand_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("grid_neighbor_expand_core verification failed");
    $finish;
  end

endmodule
